/* hw/rtl/twfc_pkg.sv */
// Shared types and constants for the triangle winding fix block.
// Depends on nothing; every other file in hw/rtl refers to it by scoped names.
package twfc_pkg;

   // Default sizing of the vertex store and the coordinates
   localparam int DEF_VERTEX_DEPTH = 4096;
   localparam int DEF_COORD_BITS   = 20;

   // Fixed field widths
   localparam int MODE_BITS = 2;
   localparam int IDX_BITS  = 12;

   // Digit size of the serial multiplier
   localparam int DIGIT_BITS = 16;
   localparam int LOG_DIGIT  = 4;

   // Command codes carried in the mode field
   localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LOAD  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_FACE  = 2'd2;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   // Control from the sequencer to the vertex store
   typedef struct packed {
      logic we;
      logic re;
   } vs_ctl_type;

   // Control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic go;    // start one product
      logic keep;  // keep the accumulator instead of loading the preset
      logic sub;   // subtract the product instead of adding it
   } mac_ctl_type;

endpackage

/* hw/rtl/twfc_vstore.sv */
// Single-port vertex store with a registered read port.
// Depends on twfc_pkg for the control struct.
module twfc_vstore #(
   parameter int DEPTH = twfc_pkg::DEF_VERTEX_DEPTH,
   parameter int WIDTH = 3 * twfc_pkg::DEF_COORD_BITS
) (
   input  logic                        clock,
   input  twfc_pkg::vs_ctl_type        ctl,
   input  logic [$clog2(DEPTH)-1:0]    addr,
   input  logic [WIDTH-1:0]            wdata,
   output logic [WIDTH-1:0]            rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write takes the port; otherwise read on request
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[addr] <= wdata;
      end else if (ctl.re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/twfc_mac.sv */
// Digit-serial signed multiply-accumulate unit: acc = (preset or acc) +/- a*b,
// one 16-bit digit of b per cycle, product registered before the add.
// Depends on twfc_pkg for the digit size and the control struct.
module twfc_mac #(
   parameter int OPW  = 43,
   parameter int ACCW = 88
) (
   input  logic                     clock,
   input  logic                     reset,
   input  twfc_pkg::mac_ctl_type    ctl,
   input  logic signed [OPW-1:0]    a_in,
   input  logic signed [OPW-1:0]    b_in,
   input  logic signed [ACCW-1:0]   preset_in,
   output logic                     done,
   output logic signed [ACCW-1:0]   acc
);

   localparam int NDIG = (OPW + twfc_pkg::DIGIT_BITS - 1) / twfc_pkg::DIGIT_BITS;
   localparam int BW   = NDIG * twfc_pkg::DIGIT_BITS;
   localparam int DGW  = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int PPW  = OPW + twfc_pkg::DIGIT_BITS + 1;

   logic signed [OPW-1:0]              a_ff;
   logic [BW-1:0]                      b_ff;
   logic                               sub_ff;
   logic signed [ACCW-1:0]             acc_ff;
   logic                               run_ff;
   logic [DGW-1:0]                     dig_ff;
   logic signed [PPW-1:0]              pp_ff;
   logic [DGW-1:0]                     pk_ff;
   logic                               pv_ff;
   logic                               plast_ff;
   logic                               done_ff;

   logic [twfc_pkg::DIGIT_BITS-1:0]    raw_dig;
   logic                               top_dig;
   logic signed [twfc_pkg::DIGIT_BITS:0] dig_s;
   logic signed [PPW-1:0]              prod;
   logic signed [ACCW-1:0]             pp_ext;
   logic signed [ACCW-1:0]             pp_sh;
   logic signed [ACCW-1:0]             acc_in;

   // Pick the current digit of b; only the top digit carries the sign
   always_comb begin
      raw_dig = b_ff[dig_ff * twfc_pkg::DIGIT_BITS +: twfc_pkg::DIGIT_BITS];
      top_dig = (dig_ff == DGW'(NDIG - 1));
      dig_s   = $signed({top_dig & raw_dig[twfc_pkg::DIGIT_BITS-1], raw_dig});
      prod    = a_ff * dig_s;
   end

   // Align the registered partial product and accumulate
   always_comb begin
      pp_ext = ACCW'(pp_ff);
      pp_sh  = pp_ext <<< {pk_ff, {twfc_pkg::LOG_DIGIT{1'b0}}};
      acc_in = sub_ff ? (acc_ff - pp_sh) : (acc_ff + pp_sh);
   end

   // Sequence digits, hold operands and the accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.go) begin
            a_ff   <= a_in;
            b_ff   <= BW'(b_in);
            sub_ff <= ctl.sub;
            if (!ctl.keep) begin
               acc_ff <= preset_in;
            end
            run_ff <= 1'b1;
            dig_ff <= '0;
            pv_ff  <= 1'b0;
         end else begin
            pv_ff <= run_ff;
            if (run_ff) begin
               pp_ff    <= prod;
               pk_ff    <= dig_ff;
               plast_ff <= top_dig;
               if (top_dig) begin
                  run_ff <= 1'b0;
               end else begin
                  dig_ff <= dig_ff + DGW'(1);
               end
            end
            if (pv_ff) begin
               acc_ff  <= acc_in;
               done_ff <= plast_ff;
            end
         end
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

/* hw/rtl/triangle_winding_fix_by_centroid.sv */
// Top level: command port, vertex count and sums, face sequencer.
// Depends on twfc_pkg, twfc_vstore and twfc_mac.
//
//   Channel   Ports                                         Transfer when
//   request   start, busy, req_mode, req_coord_*, req_index_*  start && !busy
//   response  rsp_valid, rsp_out_index_*, rsp_flipped, rsp_status  rsp_valid
//
// Clear and load do not make the block busy; an overflowing load and a face
// with no vertices loaded or a bad index answer in the cycle after the transfer.
// An oriented face makes three reads of the single-ported vertex store, then
// twelve products through the one serial multiply-accumulate unit.
// Reset (synchronous, active high) empties the store logically by clearing
// the count and sums. Results are strobed for one cycle and cannot be stalled.
module triangle_winding_fix_by_centroid #(
   parameter int VERTEX_DEPTH = twfc_pkg::DEF_VERTEX_DEPTH,
   parameter int COORD_BITS   = twfc_pkg::DEF_COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [twfc_pkg::MODE_BITS-1:0]    req_mode,
   input  logic signed [COORD_BITS-1:0]      req_coord_x,
   input  logic signed [COORD_BITS-1:0]      req_coord_y,
   input  logic signed [COORD_BITS-1:0]      req_coord_z,
   input  logic [twfc_pkg::IDX_BITS-1:0]     req_index_a,
   input  logic [twfc_pkg::IDX_BITS-1:0]     req_index_b,
   input  logic [twfc_pkg::IDX_BITS-1:0]     req_index_c,
   output logic                              rsp_valid,
   output logic [twfc_pkg::IDX_BITS-1:0]     rsp_out_index_a,
   output logic [twfc_pkg::IDX_BITS-1:0]     rsp_out_index_b,
   output logic [twfc_pkg::IDX_BITS-1:0]     rsp_out_index_c,
   output logic                              rsp_flipped,
   output logic [1:0]                        rsp_status
);

   localparam int AW   = $clog2(VERTEX_DEPTH);
   localparam int CW   = $clog2(VERTEX_DEPTH + 1);
   localparam int SUMW = COORD_BITS + AW;
   localparam int EW   = COORD_BITS + 1;
   localparam int PSW  = COORD_BITS + 2;
   localparam int NW   = 2 * COORD_BITS + 3;
   localparam int DW   = CW + COORD_BITS + 4;
   localparam int OPW  = (NW > DW) ? NW : DW;
   localparam int ACCW = 2 * OPW + 2;
   localparam int IW   = twfc_pkg::IDX_BITS;
   localparam int CMPW = (CW > IW) ? CW : IW;
   localparam int VW   = 3 * COORD_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_PREP,
      S_ISSUE,
      S_WAIT
   } state_type;

   typedef enum logic [3:0] {
      OP_N0P, OP_N0M, OP_N1P, OP_N1M, OP_N2P, OP_N2M,
      OP_DX, OP_DY, OP_DZ, OP_TX, OP_TY, OP_TZ
   } op_type;

   // Sequencer and result registers
   state_type               state_ff;
   op_type                  op_ff;
   logic [1:0]              ph_ff;
   logic                    rsp_valid_ff;
   logic [IW-1:0]           rsp_a_ff;
   logic [IW-1:0]           rsp_b_ff;
   logic [IW-1:0]           rsp_c_ff;
   logic                    rsp_flip_ff;
   twfc_pkg::status_type    rsp_status_ff;

   // Vertex bookkeeping
   logic [CW-1:0]           count_ff;
   logic signed [SUMW-1:0]  sum_ff [3];

   // Face datapath registers
   logic [IW-1:0]           idx_ff [3];
   logic signed [COORD_BITS-1:0] p_ff [3][3];
   logic signed [EW-1:0]    e1_ff [3];
   logic signed [EW-1:0]    e2_ff [3];
   logic signed [PSW-1:0]   ps_ff [3];
   logic signed [OPW-1:0]   n_ff [3];
   logic signed [OPW-1:0]   d_ff [3];

   logic                    accept;
   logic                    full;
   logic                    bad_index;
   logic [IW-1:0]           req_idx [3];
   logic signed [COORD_BITS-1:0] req_coord [3];

   twfc_pkg::vs_ctl_type    vs_ctl;
   logic [AW-1:0]           vs_addr;
   logic [VW-1:0]           vs_rdata;

   twfc_pkg::mac_ctl_type   mac_ctl;
   logic signed [OPW-1:0]   mac_a;
   logic signed [OPW-1:0]   mac_b;
   logic signed [ACCW-1:0]  mac_preset;
   logic                    mac_done;
   logic signed [ACCW-1:0]  mac_acc;
   logic signed [ACCW-1:0]  sum_ext;
   logic signed [OPW-1:0]   cnt_op;

   assign req_idx[0]   = req_index_a;
   assign req_idx[1]   = req_index_b;
   assign req_idx[2]   = req_index_c;
   assign req_coord[0] = req_coord_x;
   assign req_coord[1] = req_coord_y;
   assign req_coord[2] = req_coord_z;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign full   = (count_ff >= CW'(VERTEX_DEPTH));

   // Flag any face index at or beyond the loaded count
   always_comb begin
      bad_index = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (CMPW'(req_idx[k]) >= CMPW'(count_ff)) begin
            bad_index = 1'b1;
         end
      end
   end

   // Store port: a load writes at the count, the face reads a, b, c in turn
   always_comb begin
      vs_ctl.we = accept && (req_mode == twfc_pkg::MODE_LOAD) && !full;
      vs_ctl.re = (state_ff == S_READ) && (ph_ff != 2'd3);
      if (vs_ctl.we) begin
         vs_addr = count_ff[AW-1:0];
      end else begin
         unique case (ph_ff)
            2'd0:    vs_addr = AW'(idx_ff[0]);
            2'd1:    vs_addr = AW'(idx_ff[1]);
            default: vs_addr = AW'(idx_ff[2]);
         endcase
      end
   end

   twfc_vstore #(
      .DEPTH (VERTEX_DEPTH),
      .WIDTH (VW)
   ) u_vstore (
      .clock (clock),
      .ctl   (vs_ctl),
      .addr  (vs_addr),
      .wdata ({req_coord_z, req_coord_y, req_coord_x}),
      .rdata (vs_rdata)
   );

   // Operand selection for each step of the product schedule
   always_comb begin
      cnt_op      = OPW'($signed({1'b0, count_ff}));
      sum_ext     = '0;
      mac_a       = '0;
      mac_b       = '0;
      mac_preset  = '0;
      mac_ctl.go  = (state_ff == S_ISSUE);
      mac_ctl.keep = 1'b0;
      mac_ctl.sub  = 1'b0;
      unique case (op_ff)
         OP_N0P: begin
            mac_a = OPW'(e1_ff[1]);
            mac_b = OPW'(e2_ff[2]);
         end
         OP_N0M: begin
            mac_a = OPW'(e1_ff[2]);
            mac_b = OPW'(e2_ff[1]);
            mac_ctl.keep = 1'b1;
            mac_ctl.sub  = 1'b1;
         end
         OP_N1P: begin
            mac_a = OPW'(e1_ff[2]);
            mac_b = OPW'(e2_ff[0]);
         end
         OP_N1M: begin
            mac_a = OPW'(e1_ff[0]);
            mac_b = OPW'(e2_ff[2]);
            mac_ctl.keep = 1'b1;
            mac_ctl.sub  = 1'b1;
         end
         OP_N2P: begin
            mac_a = OPW'(e1_ff[0]);
            mac_b = OPW'(e2_ff[1]);
         end
         OP_N2M: begin
            mac_a = OPW'(e1_ff[1]);
            mac_b = OPW'(e2_ff[0]);
            mac_ctl.keep = 1'b1;
            mac_ctl.sub  = 1'b1;
         end
         OP_DX: begin
            sum_ext    = ACCW'(sum_ff[0]);
            mac_a      = OPW'(ps_ff[0]);
            mac_b      = cnt_op;
            mac_preset = -(sum_ext + (sum_ext <<< 1));
         end
         OP_DY: begin
            sum_ext    = ACCW'(sum_ff[1]);
            mac_a      = OPW'(ps_ff[1]);
            mac_b      = cnt_op;
            mac_preset = -(sum_ext + (sum_ext <<< 1));
         end
         OP_DZ: begin
            sum_ext    = ACCW'(sum_ff[2]);
            mac_a      = OPW'(ps_ff[2]);
            mac_b      = cnt_op;
            mac_preset = -(sum_ext + (sum_ext <<< 1));
         end
         OP_TX: begin
            mac_a = n_ff[0];
            mac_b = d_ff[0];
         end
         OP_TY: begin
            mac_a = n_ff[1];
            mac_b = d_ff[1];
            mac_ctl.keep = 1'b1;
         end
         OP_TZ: begin
            mac_a = n_ff[2];
            mac_b = d_ff[2];
            mac_ctl.keep = 1'b1;
         end
         default: begin
            mac_ctl.go = 1'b0;
         end
      endcase
   end

   twfc_mac #(
      .OPW  (OPW),
      .ACCW (ACCW)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .a_in      (mac_a),
      .b_in      (mac_b),
      .preset_in (mac_preset),
      .done      (mac_done),
      .acc       (mac_acc)
   );

   // Sequencer, count and sums, result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_N0P;
         ph_ff        <= 2'd0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_mode)
                     twfc_pkg::MODE_CLEAR: begin
                        count_ff <= '0;
                        for (int k = 0; k < 3; k++) begin
                           sum_ff[k] <= '0;
                        end
                     end
                     twfc_pkg::MODE_LOAD: begin
                        if (full) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_a_ff      <= '0;
                           rsp_b_ff      <= '0;
                           rsp_c_ff      <= '0;
                           rsp_flip_ff   <= 1'b0;
                           rsp_status_ff <= twfc_pkg::STATUS_OVERFLOW;
                        end else begin
                           count_ff <= count_ff + CW'(1);
                           for (int k = 0; k < 3; k++) begin
                              sum_ff[k] <= sum_ff[k] + SUMW'(req_coord[k]);
                           end
                        end
                     end
                     twfc_pkg::MODE_FACE: begin
                        rsp_a_ff    <= req_index_a;
                        rsp_b_ff    <= req_index_b;
                        rsp_c_ff    <= req_index_c;
                        rsp_flip_ff <= 1'b0;
                        if (count_ff == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= twfc_pkg::STATUS_OK;
                        end else if (bad_index) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= twfc_pkg::STATUS_BAD_INDEX;
                        end else begin
                           state_ff <= S_READ;
                           ph_ff    <= 2'd0;
                        end
                     end
                     default: begin
                        // unused command: drop it
                     end
                  endcase
               end
            end
            S_READ: begin
               ph_ff <= ph_ff + 2'd1;
               if (ph_ff == 2'd3) begin
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               op_ff    <= OP_N0P;
               state_ff <= S_ISSUE;
            end
            S_ISSUE: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (mac_done) begin
                  if (op_ff == OP_TZ) begin
                     state_ff      <= S_IDLE;
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= twfc_pkg::STATUS_OK;
                     rsp_flip_ff   <= mac_acc[ACCW-1];
                     if (mac_acc[ACCW-1]) begin
                        rsp_b_ff <= rsp_c_ff;
                        rsp_c_ff <= rsp_b_ff;
                     end
                  end else begin
                     op_ff    <= op_type'(op_ff + 4'd1);
                     state_ff <= S_ISSUE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Face datapath: latch indices, shift in vertices, form edges and sums,
   // and hold the normal and offset components
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < 3; k++) begin
            idx_ff[k] <= req_idx[k];
         end
      end
      if (state_ff == S_READ && ph_ff != 2'd0) begin
         for (int ax = 0; ax < 3; ax++) begin
            p_ff[0][ax] <= p_ff[1][ax];
            p_ff[1][ax] <= p_ff[2][ax];
            p_ff[2][ax] <= vs_rdata[ax * COORD_BITS +: COORD_BITS];
         end
      end
      if (state_ff == S_PREP) begin
         for (int ax = 0; ax < 3; ax++) begin
            e1_ff[ax] <= EW'(p_ff[1][ax]) - EW'(p_ff[0][ax]);
            e2_ff[ax] <= EW'(p_ff[2][ax]) - EW'(p_ff[0][ax]);
            ps_ff[ax] <= PSW'(p_ff[0][ax]) + PSW'(p_ff[1][ax]) + PSW'(p_ff[2][ax]);
         end
      end
      if (state_ff == S_WAIT && mac_done) begin
         unique case (op_ff)
            OP_N0M:  n_ff[0] <= mac_acc[OPW-1:0];
            OP_N1M:  n_ff[1] <= mac_acc[OPW-1:0];
            OP_N2M:  n_ff[2] <= mac_acc[OPW-1:0];
            OP_DX:   d_ff[0] <= mac_acc[OPW-1:0];
            OP_DY:   d_ff[1] <= mac_acc[OPW-1:0];
            OP_DZ:   d_ff[2] <= mac_acc[OPW-1:0];
            default: begin
               // partial sums stay in the accumulator
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_index_a = rsp_a_ff;
   assign rsp_out_index_b = rsp_b_ff;
   assign rsp_out_index_c = rsp_c_ff;
   assign rsp_flipped     = rsp_flip_ff;
   assign rsp_status      = rsp_status_ff;

   // A result only appears once the sequencer is back in idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while a face is in progress");

   // The vertex count never runs past the store depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(VERTEX_DEPTH))
      else $error("vertex count beyond store depth");

   // The multiplier only finishes while the sequencer waits for it
   a_mac_done_wait: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == S_WAIT))
      else $error("product finished outside the wait state");

   // A store write never collides with a face read
   a_store_port: assert property (@(posedge clock) disable iff (reset)
      vs_ctl.we |-> !vs_ctl.re)
      else $error("store written during a face read");

   // A reversed face always reports a clean status
   a_flip_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flipped) |-> (rsp_status == twfc_pkg::STATUS_OK))
      else $error("flipped face with an error status");

endmodule

/* sim/tb_triangle_winding_fix_by_centroid.sv */
// Self-checking testbench for triangle_winding_fix_by_centroid.
// Depends on twfc_pkg and the block's RTL; holds its own orientation predictor
// and a scoreboard class, with plain tasks driving the command port.
module tb_triangle_winding_fix_by_centroid;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IW    = twfc_pkg::IDX_BITS;
   localparam int CW    = twfc_pkg::DEF_COORD_BITS;
   localparam int MW    = twfc_pkg::MODE_BITS;
   localparam int DEPTH = twfc_pkg::DEF_VERTEX_DEPTH;
   localparam int WW    = 160;
   localparam int RANDOM_ITEMS = 650;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam logic [MW-1:0] MODE_UNUSED = 2'd3;
   localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

   typedef struct {
      logic [IW-1:0]        a;
      logic [IW-1:0]        b;
      logic [IW-1:0]        c;
      logic                 flipped;
      twfc_pkg::status_type status;
   } face_result_type;

   // Predicts orientation results and checks them in order
   class winding_scoreboard;
      logic signed [CW-1:0] vx [DEPTH];
      logic signed [CW-1:0] vy [DEPTH];
      logic signed [CW-1:0] vz [DEPTH];
      int unsigned  count;
      longint       tot [3];
      face_result_type awaited_results [$];
      int mismatches;
      int faces;
      int flips;
      int bad_index;
      int overflows;

      function new();
         count = 0;
         foreach (tot[i]) tot[i] = 0;
         mismatches = 0;
         faces = 0;
         flips = 0;
         bad_index = 0;
         overflows = 0;
      endfunction

      // Append one expected result at the tail
      function void queue_result(face_result_type r);
         awaited_results.insert(awaited_results.size(), r);
      endfunction

      // Sign of normal . (3N * (face center - centroid)), exact at 160 bits
      function bit face_flips(logic [IW-1:0] ia, logic [IW-1:0] ib, logic [IW-1:0] ic);
         logic [IW-1:0]        ids [3];
         logic signed [WW-1:0] pt [3][3];
         logic signed [WW-1:0] e1 [3];
         logic signed [WW-1:0] e2 [3];
         logic signed [WW-1:0] off [3];
         logic signed [WW-1:0] nrm [3];
         logic signed [WW-1:0] cnt;
         logic signed [WW-1:0] sw;
         logic signed [WW-1:0] dot;
         ids[0] = ia;
         ids[1] = ib;
         ids[2] = ic;
         cnt = WW'(count);
         for (int k = 0; k < 3; k++) begin
            pt[k][0] = WW'(vx[ids[k]]);
            pt[k][1] = WW'(vy[ids[k]]);
            pt[k][2] = WW'(vz[ids[k]]);
         end
         for (int ax = 0; ax < 3; ax++) begin
            sw = WW'(tot[ax]);
            e1[ax] = pt[1][ax] - pt[0][ax];
            e2[ax] = pt[2][ax] - pt[0][ax];
            off[ax] = cnt * (pt[0][ax] + pt[1][ax] + pt[2][ax]) - 3 * sw;
         end
         nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
         nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
         nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
         dot = nrm[0] * off[0] + nrm[1] * off[1] + nrm[2] * off[2];
         return dot[WW-1];
      endfunction

      // Update the model state for one transfer and queue its result, if any
      function void note_request(logic [MW-1:0] mode, logic signed [CW-1:0] x,
                                 logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                                 logic [IW-1:0] a, logic [IW-1:0] b, logic [IW-1:0] c);
         face_result_type r;
         bit flip;
         case (mode)
            twfc_pkg::MODE_CLEAR: begin
               count = 0;
               foreach (tot[i]) tot[i] = 0;
            end
            twfc_pkg::MODE_LOAD: begin
               if (count >= DEPTH) begin
                  r.a = '0;
                  r.b = '0;
                  r.c = '0;
                  r.flipped = 1'b0;
                  r.status = twfc_pkg::STATUS_OVERFLOW;
                  queue_result(r);
                  overflows++;
               end else begin
                  vx[count] = x;
                  vy[count] = y;
                  vz[count] = z;
                  count++;
                  tot[0] += longint'(x);
                  tot[1] += longint'(y);
                  tot[2] += longint'(z);
               end
            end
            twfc_pkg::MODE_FACE: begin
               flip = 1'b0;
               r.status = twfc_pkg::STATUS_OK;
               if (count != 0) begin
                  if (a >= count || b >= count || c >= count) begin
                     r.status = twfc_pkg::STATUS_BAD_INDEX;
                     bad_index++;
                  end else begin
                     flip = face_flips(a, b, c);
                  end
               end
               r.a = a;
               r.b = flip ? c : b;
               r.c = flip ? b : c;
               r.flipped = flip;
               queue_result(r);
               faces++;
               if (flip) flips++;
            end
            default: ;
         endcase
      endfunction

      // Compare one strobed result with the oldest expectation
      function void check_result(logic [IW-1:0] a, logic [IW-1:0] b, logic [IW-1:0] c,
                                 logic flip, logic [1:0] status);
         face_result_type want;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected result: idx %0d %0d %0d flipped %0b status %0d",
                        $realtime, a, b, c, flip, status);
            return;
         end
         want = awaited_results.pop_front();
         if (a !== want.a || b !== want.b || c !== want.c || flip !== want.flipped ||
             status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] mismatch: expected idx %0d %0d %0d flipped %0b status %0d,",
                        $realtime, want.a, want.b, want.c, want.flipped, want.status);
               $display("    got idx %0d %0d %0d flipped %0b status %0d",
                        a, b, c, flip, status);
            end
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [MW-1:0]        req_mode;
   logic signed [CW-1:0] req_coord_x;
   logic signed [CW-1:0] req_coord_y;
   logic signed [CW-1:0] req_coord_z;
   logic [IW-1:0]        req_index_a;
   logic [IW-1:0]        req_index_b;
   logic [IW-1:0]        req_index_c;
   logic                 rsp_valid;
   logic [IW-1:0]        rsp_out_index_a;
   logic [IW-1:0]        rsp_out_index_b;
   logic [IW-1:0]        rsp_out_index_c;
   logic                 rsp_flipped;
   logic [1:0]           rsp_status;

   winding_scoreboard sb;
   int sent;
   int calm_left;
   int cycles;

   triangle_winding_fix_by_centroid dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_index_a     (req_index_a),
      .req_index_b     (req_index_b),
      .req_index_c     (req_index_c),
      .rsp_valid       (rsp_valid),
      .rsp_out_index_a (rsp_out_index_a),
      .rsp_out_index_b (rsp_out_index_b),
      .rsp_out_index_c (rsp_out_index_c),
      .rsp_flipped     (rsp_flipped),
      .rsp_status      (rsp_status)
   );

   // Free-running clock
   always #6 clock = ~clock;

   // Check every strobed result
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_out_index_a, rsp_out_index_b, rsp_out_index_c,
                         rsp_flipped, rsp_status);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, sb.awaited_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Idle cycles before the next transfer, with occasional runs of none
   function automatic int draw_gap();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(19, 0) == 0) calm_left = $urandom_range(40, 5);
      return $urandom_range(11, 0);
   endfunction

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(9, 0))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2, 3, 4: return CW'($signed($urandom_range(64, 0)) - 32);
         default: return CW'($urandom);
      endcase
   endfunction

   // Drive one command and hold it until the block takes the transfer
   task automatic send(logic [MW-1:0] mode, logic signed [CW-1:0] x,
                       logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                       logic [IW-1:0] a, logic [IW-1:0] b, logic [IW-1:0] c);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode    <= mode;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_index_a <= a;
      req_index_b <= b;
      req_index_c <= c;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(mode, x, y, z, a, b, c);
      if (mode != MODE_UNUSED) sent++;
   endtask

   task automatic clear_store();
      send(twfc_pkg::MODE_CLEAR, rand_coord(), rand_coord(), rand_coord(),
           IW'($urandom), IW'($urandom), IW'($urandom));
   endtask

   task automatic load(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                       logic signed [CW-1:0] z);
      send(twfc_pkg::MODE_LOAD, x, y, z, IW'($urandom), IW'($urandom), IW'($urandom));
   endtask

   task automatic face(int a, int b, int c);
      send(twfc_pkg::MODE_FACE, rand_coord(), rand_coord(), rand_coord(),
           IW'(a), IW'(b), IW'(c));
   endtask

   task automatic noise();
      send(MODE_UNUSED, rand_coord(), rand_coord(), rand_coord(),
           IW'($urandom), IW'($urandom), IW'($urandom));
   endtask

   // Mostly valid faces, some degenerate, some pointing past the loaded vertices
   task automatic random_face();
      int unsigned n;
      int kind;
      int ia;
      int ib;
      int ic;
      n = sb.count;
      kind = $urandom_range(99, 0);
      if (n == 0 || kind < 8) begin
         ia = $urandom;
         ib = $urandom;
         ic = $urandom;
      end else begin
         ia = $urandom_range(n - 1, 0);
         ib = $urandom_range(n - 1, 0);
         ic = $urandom_range(n - 1, 0);
         if (kind < 14)
            ib = ia;
         else if (kind < 22 && n < DEPTH)
            ic = $urandom_range(DEPTH - 1, n);
      end
      face(ia, ib, ic);
   endtask

   // Hold off the sender until every queued result has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.awaited_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      int base;
      int nl;
      int nf;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_mode = twfc_pkg::MODE_CLEAR;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      req_index_a = '0;
      req_index_b = '0;
      req_index_c = '0;
      sent = 0;
      calm_left = 0;
      cycles = 0;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty store, extremes, centroid face, degenerate and bad indices
      face(DEPTH - 1, 0, DEPTH - 1);
      noise();
      load(COORD_MIN, COORD_MAX, CW'(0));
      load(COORD_MAX, COORD_MIN, CW'(-1));
      load(CW'(0), CW'(0), COORD_MAX);
      face(0, 1, 2);
      load(CW'(1), CW'(-1), COORD_MIN);
      face(0, 1, 2);
      face(0, 2, 1);
      face(1, 2, 3);
      face(3, 2, 1);
      face(0, 0, 1);
      face(0, 1, 4);
      face(DEPTH - 1, 1, 2);
      face(4, 4, 4);
      clear_store();
      face(0, 1, 2);
      load(CW'(0), CW'(0), CW'(0));
      load(CW'(100), CW'(0), CW'(0));
      load(CW'(0), CW'(100), CW'(0));
      load(CW'(0), CW'(0), CW'(100));
      face(1, 2, 3);
      face(1, 3, 2);
      noise();
      clear_store();

      // Random meshes: load a batch, orient faces against it, clear now and then
      base = sent;
      while (sent - base < RANDOM_ITEMS) begin
         if ($urandom_range(99, 0) < 20) begin
            if ($urandom_range(1, 0) == 1) drain_results();
            clear_store();
            if ($urandom_range(3, 0) == 0) random_face();
         end
         nl = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 25) : $urandom_range(8, 0);
         repeat (nl) load(rand_coord(), rand_coord(), rand_coord());
         nf = $urandom_range(10, 1);
         repeat (nf) begin
            random_face();
            if ($urandom_range(29, 0) == 0) noise();
         end
      end

      // Settle, empty the store and orient one face against it
      drain_results();
      clear_store();
      face(DEPTH - 1, DEPTH - 1, 0);

      // Let the last results come back
      start <= 1'b0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Ran %0d commands over random meshes: %0d faces, %0d reversed,",
               sent, sb.faces, sb.flips);
      $display("%0d with an unloaded index, %0d dropped loads; %0d mismatches, %0d left.",
               sb.bad_index, sb.overflows, sb.mismatches, sb.awaited_results.size());
      if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
